// File: rtl/core/two_level_feedback_scheduler_defines.svh
// assertion macros for the two-level feedback scheduler
`ifndef TWO_LEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`define TWO_LEVEL_FEEDBACK_SCHEDULER_DEFINES_SVH
`ifndef ASSERT_OFF
`define TLFS_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) else $error(msg);
`define TLFS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define TLFS_ASSERT_NOW(lbl, pre, post, msg)
`define TLFS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// File: rtl/core/tlfs_pkg.sv
// types and constants of the two-level feedback scheduler
`timescale 1ns / 1ps
package tlfs_pkg;
	localparam int unsigned ID_W = 8;
	localparam int unsigned PRIO_W = 8;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned STAMP_W = 16;
	localparam int unsigned QUANT_W = 4;
	localparam logic [QUANT_W-1:0] QUANT_RESET = 4'd4;

	typedef enum logic {
		REG_QUANTUM_HIGH = 1'b0,
		REG_QUANTUM_LOW  = 1'b1
	} reg_idx_t;

	localparam logic FUNC_ARRIVAL = 1'b0;
	localparam logic FUNC_TICK = 1'b1;
	localparam logic LEVEL_HIGH = 1'b0;
	localparam logic LEVEL_LOW = 1'b1;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [PRIO_W-1:0]  prio;
		logic [LEN_W-1:0]   rem;
		logic [STAMP_W-1:0] order;
	} hi_entry_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [LEN_W-1:0] rem;
	} lo_entry_t;

	typedef struct packed {
		logic            ran;
		logic [ID_W-1:0] run_id;
		logic            run_level;
		logic            finished;
		logic            dropped;
	} res_t;

	typedef struct packed {
		logic in_ready;
		logic scan_start;
		logic scan_rd;
		logic drop_res;
		logic arr_do;
		logic idle_res;
		logic rot_wr;
		logic hi_run;
		logic lo_run;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic func;
		logic full;
		logic scan_last;
		logic found;
		logic need_rot;
		logic lo_nonempty;
		logic out_free;
	} sts_t;
endpackage

// File: rtl/core/tlfs_if.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface tlfs_req_if;
	import tlfs_pkg::*;
	logic                valid;
	logic                ready;
	logic                func;
	logic [ID_W-1:0]     task_id;
	logic [PRIO_W-1:0]   task_prio;
	logic [LEN_W-1:0]    burst_len;
	modport source (output valid, func, task_id, task_prio, burst_len, input ready);
	modport sink (input valid, func, task_id, task_prio, burst_len, output ready);
endinterface

interface tlfs_rsp_if;
	import tlfs_pkg::*;
	logic            valid;
	logic            ready;
	logic            ran;
	logic [ID_W-1:0] run_id;
	logic            run_level;
	logic            finished;
	logic            dropped;
	modport source (output valid, ran, run_id, run_level, finished, dropped, input ready);
	modport sink (input valid, ran, run_id, run_level, finished, dropped, output ready);
endinterface

// File: rtl/core/tlfs_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
module tlfs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// File: rtl/core/tlfs_ctrl.sv
// controller state machine of the scheduler
`timescale 1ns / 1ps
module tlfs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  tlfs_pkg::sts_t sts,
	output tlfs_pkg::cmd_t cmd
);
	import tlfs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_SCAN_LAST,
		ST_DECIDE,
		ST_ROT_WR,
		ST_HI_RUN,
		ST_LO_RUN,
		ST_DONE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (sts.func == FUNC_ARRIVAL && sts.full) begin
					cmd.drop_res = 1'b1;
					state_d = ST_DONE;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.scan_last) state_d = ST_SCAN_LAST;
			end
			ST_SCAN_LAST: state_d = ST_DECIDE;
			ST_DECIDE: begin
				priority if (sts.func == FUNC_ARRIVAL) begin
					cmd.arr_do = 1'b1;
					state_d = ST_DONE;
				end else if (sts.found && sts.need_rot) begin
					state_d = ST_ROT_WR;
				end else if (sts.found) begin
					state_d = ST_HI_RUN;
				end else if (sts.lo_nonempty) begin
					state_d = ST_LO_RUN;
				end else begin
					cmd.idle_res = 1'b1;
					state_d = ST_DONE;
				end
			end
			ST_ROT_WR: begin
				cmd.rot_wr = 1'b1;
				state_d = ST_HI_RUN;
			end
			ST_HI_RUN: begin
				cmd.hi_run = 1'b1;
				state_d = ST_DONE;
			end
			ST_LO_RUN: begin
				cmd.lo_run = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// File: rtl/core/tlfs_dp.sv
// datapath of the scheduler: task tables, queue pointers, slice counters
`timescale 1ns / 1ps
module tlfs_dp #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tlfs_req_if.sink                   req,
	tlfs_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic                       cfg_idx,
	input  logic [tlfs_pkg::QUANT_W-1:0] cfg_data,
	input  tlfs_pkg::cmd_t             cmd,
	output tlfs_pkg::sts_t             sts
);
	import tlfs_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic               func_q;
	logic [ID_W-1:0]    id_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [LEN_W-1:0]   burst_q;
	logic [QUANT_W-1:0] qh_q, ql_q, hi_slice_q, lo_slice_q;
	logic [DEPTH-1:0]   valid_q;
	logic [CW-1:0]      hi_count_q, lo_count_q;
	logic [AW-1:0]      lo_head_q, lo_tail_q;
	logic [STAMP_W-1:0] stamp_q;
	logic [AW-1:0]      scan_cnt_q, idx_s1;
	logic               scan_s1, vld_s1;
	logic               found_q, free_found_q;
	logic [AW-1:0]      best_idx_q, free_idx_q;
	logic [ID_W-1:0]    best_id_q;
	logic [PRIO_W-1:0]  best_prio_q;
	logic [LEN_W-1:0]   best_rem_q;
	logic [STAMP_W-1:0] best_order_q, best_age_q;
	res_t               res_q, out_q;
	logic               out_valid_q;

	hi_entry_t          hi_rd, hi_wdata;
	lo_entry_t          lo_rd, lo_wdata;
	logic               hi_we, lo_we;
	logic [AW-1:0]      hi_waddr, lo_waddr, slot;
	logic [STAMP_W-1:0] age_s1;
	logic               better, demote, in_fire;
	logic               hi_last, hi_expire, hi_remove, hi_push;
	logic               lo_last, lo_expire, lo_adv;
	logic [LEN_W-1:0]   hi_rem_dec, lo_rem_dec;

	tlfs_ram #(.WIDTH($bits(hi_entry_t)), .DEPTH(DEPTH)) u_hi_ram (
		.clk   (clk),
		.we    (hi_we),
		.waddr (hi_waddr),
		.wdata (hi_wdata),
		.re    (cmd.scan_rd),
		.raddr (scan_cnt_q),
		.rdata (hi_rd)
	);

	tlfs_ram #(.WIDTH($bits(lo_entry_t)), .DEPTH(DEPTH)) u_lo_ram (
		.clk   (clk),
		.we    (lo_we),
		.waddr (lo_waddr),
		.wdata (lo_wdata),
		.re    (1'b1),
		.raddr (lo_head_q),
		.rdata (lo_rd)
	);

	assign in_fire = req.valid && req.ready;
	assign req.ready = cmd.in_ready;

	assign age_s1 = stamp_q - hi_rd.order;
	assign better = scan_s1 && vld_s1 && (!found_q || hi_rd.prio < best_prio_q ||
		(hi_rd.prio == best_prio_q && age_s1 > best_age_q));

	assign demote = found_q && hi_slice_q != qh_q && prio_q < best_prio_q;
	assign slot = (demote && best_idx_q < free_idx_q) ? best_idx_q : free_idx_q;

	assign hi_rem_dec = best_rem_q - 1'b1;
	assign hi_last = best_rem_q[LEN_W-1:1] == '0;
	assign hi_expire = hi_slice_q[QUANT_W-1:1] == '0;
	assign hi_remove = cmd.hi_run && (hi_last || hi_expire);
	assign hi_push = cmd.hi_run && !hi_last && hi_expire;

	assign lo_rem_dec = lo_rd.rem - 1'b1;
	assign lo_last = lo_rd.rem[LEN_W-1:1] == '0;
	assign lo_expire = lo_slice_q[QUANT_W-1:1] == '0;
	assign lo_adv = cmd.lo_run && (lo_last || lo_expire);

	always_comb begin
		hi_we = 1'b0;
		hi_waddr = slot;
		hi_wdata = '{id: id_q, prio: prio_q, rem: burst_q, order: stamp_q};
		if (cmd.arr_do) begin
			hi_we = 1'b1;
		end else if (cmd.hi_run && !hi_last && !hi_expire) begin
			hi_we = 1'b1;
			hi_waddr = best_idx_q;
			hi_wdata = '{id: best_id_q, prio: best_prio_q, rem: hi_rem_dec,
				order: best_order_q};
		end
	end

	always_comb begin
		lo_we = 1'b0;
		lo_waddr = lo_tail_q;
		lo_wdata = '{id: best_id_q, rem: best_rem_q};
		priority if (cmd.arr_do && demote) begin
			lo_we = 1'b1;
		end else if (cmd.rot_wr) begin
			lo_we = 1'b1;
			lo_wdata = lo_rd;
		end else if (hi_push) begin
			lo_we = 1'b1;
			lo_wdata = '{id: best_id_q, rem: hi_rem_dec};
		end else if (cmd.lo_run && !lo_last) begin
			lo_we = 1'b1;
			lo_waddr = lo_expire ? lo_tail_q : lo_head_q;
			lo_wdata = '{id: lo_rd.id, rem: lo_rem_dec};
		end
	end

	always_comb begin
		sts.in_valid = req.valid;
		sts.func = func_q;
		sts.full = ({1'b0, hi_count_q} + {1'b0, lo_count_q}) >= (CW + 1)'(DEPTH);
		sts.scan_last = scan_cnt_q == AW'(DEPTH - 1);
		sts.found = found_q;
		sts.need_rot = lo_slice_q != ql_q && lo_count_q != '0;
		sts.lo_nonempty = lo_count_q != '0;
		sts.out_free = !out_valid_q || rsp.ready;
	end

	// input, scan and result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			func_q <= req.func;
			id_q <= req.task_id;
			prio_q <= req.task_prio;
			burst_q <= req.burst_len;
		end
		idx_s1 <= scan_cnt_q;
		vld_s1 <= valid_q[scan_cnt_q];
		if (better) begin
			best_idx_q <= idx_s1;
			best_id_q <= hi_rd.id;
			best_prio_q <= hi_rd.prio;
			best_rem_q <= hi_rd.rem;
			best_order_q <= hi_rd.order;
			best_age_q <= age_s1;
		end
		if (cmd.scan_rd && !valid_q[scan_cnt_q] && !free_found_q) begin
			free_idx_q <= scan_cnt_q;
		end
		if (cmd.load_out) begin
			out_q <= res_q;
		end
		unique case (1'b1)
			cmd.drop_res: res_q <= '{ran: 1'b0, run_id: '0, run_level: LEVEL_HIGH,
				finished: 1'b0, dropped: 1'b1};
			cmd.arr_do, cmd.idle_res: res_q <= '0;
			cmd.hi_run: res_q <= '{ran: 1'b1, run_id: best_id_q, run_level: LEVEL_HIGH,
				finished: hi_last, dropped: 1'b0};
			cmd.lo_run: res_q <= '{ran: 1'b1, run_id: lo_rd.id, run_level: LEVEL_LOW,
				finished: lo_last, dropped: 1'b0};
			default: res_q <= res_q;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qh_q <= QUANT_RESET;
			ql_q <= QUANT_RESET;
			hi_slice_q <= QUANT_RESET;
			lo_slice_q <= QUANT_RESET;
			valid_q <= '0;
			hi_count_q <= '0;
			lo_count_q <= '0;
			lo_head_q <= '0;
			lo_tail_q <= '0;
			stamp_q <= '0;
			scan_cnt_q <= '0;
			scan_s1 <= 1'b0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (reg_idx_t'(cfg_idx))
					REG_QUANTUM_HIGH: qh_q <= cfg_data;
					REG_QUANTUM_LOW: ql_q <= cfg_data;
					default: qh_q <= qh_q;
				endcase
			end
			scan_s1 <= cmd.scan_rd;
			if (cmd.scan_start) begin
				scan_cnt_q <= '0;
				found_q <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					scan_cnt_q <= scan_cnt_q + 1'b1;
					if (!valid_q[scan_cnt_q]) free_found_q <= 1'b1;
				end
				if (better) found_q <= 1'b1;
			end
			if (cmd.arr_do) begin
				if (demote) begin
					valid_q[best_idx_q] <= 1'b0;
					hi_slice_q <= qh_q;
					lo_tail_q <= ptr_inc(lo_tail_q);
					lo_count_q <= lo_count_q + 1'b1;
				end else begin
					hi_count_q <= hi_count_q + 1'b1;
				end
				valid_q[slot] <= 1'b1;
				stamp_q <= stamp_q + 1'b1;
			end
			if (cmd.rot_wr) begin
				lo_head_q <= ptr_inc(lo_head_q);
				lo_tail_q <= ptr_inc(lo_tail_q);
				lo_slice_q <= ql_q;
			end
			if (cmd.hi_run) begin
				if (hi_remove) begin
					valid_q[best_idx_q] <= 1'b0;
					hi_count_q <= hi_count_q - 1'b1;
					hi_slice_q <= qh_q;
				end else begin
					hi_slice_q <= hi_slice_q - 1'b1;
				end
				if (hi_push) begin
					lo_tail_q <= ptr_inc(lo_tail_q);
					lo_count_q <= lo_count_q + 1'b1;
				end
			end
			if (cmd.lo_run) begin
				if (lo_adv) begin
					lo_head_q <= ptr_inc(lo_head_q);
					lo_slice_q <= ql_q;
				end else begin
					lo_slice_q <= lo_slice_q - 1'b1;
				end
				if (lo_last) begin
					lo_count_q <= lo_count_q - 1'b1;
				end else if (lo_expire) begin
					lo_tail_q <= ptr_inc(lo_tail_q);
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.ran = out_q.ran;
	assign rsp.run_id = out_q.run_id;
	assign rsp.run_level = out_q.run_level;
	assign rsp.finished = out_q.finished;
	assign rsp.dropped = out_q.dropped;
endmodule

// File: rtl/core/two_level_feedback_scheduler.sv
// top level of the two-level feedback scheduler
//
//   channel  dir  handshake      payload
//   req      in   valid/ready    func, task_id, task_prio, burst_len
//   rsp      out  valid/ready    ran, run_id, run_level, finished, dropped
//   cfg      in   cfg_we         cfg_idx, cfg_data
//
// one transaction at a time; a tick or a non-full arrival scans the whole
// priority table, one entry a cycle, and a dropped arrival skips the scan
// req is taken again once the result sits in the output register
// arst_n clears both levels; the table contents need no clearing pass
`timescale 1ns / 1ps
`include "two_level_feedback_scheduler_defines.svh"
module two_level_feedback_scheduler #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tlfs_req_if.sink                     req,
	tlfs_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic                         cfg_idx,
	input  logic [tlfs_pkg::QUANT_W-1:0] cfg_data
);
	import tlfs_pkg::*;

	cmd_t cmd;
	sts_t sts;

	tlfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	tlfs_dp #(.DEPTH(DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

	`TLFS_ASSERT_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "req taken twice")
	`TLFS_ASSERT_NOW(a_drop_no_run, rsp.valid && rsp.dropped, !rsp.ran, "dropped with run")
	`TLFS_ASSERT_NOW(a_fin_ran, rsp.valid && rsp.finished, rsp.ran, "finished without run")
	`TLFS_ASSERT_NOW(a_idle_zero, rsp.valid && !rsp.ran,
		rsp.run_id == '0 && rsp.run_level == LEVEL_HIGH, "idle result not zero")
endmodule
